// ----- src/pcgf_pkg.sv -----
// Package for the pitch contour octave fix and gap fill block.
// Holds the item types of both channels and the fixed-point constants.
// No dependencies.
`default_nettype none

package pcgf_pkg;

    // One input item: a pitch frame and its end-of-contour mark.
    typedef struct packed {
        logic [15:0] pitch_in;
        logic        end_of_contour;
    } frame_t;

    // One result item.
    typedef struct packed {
        logic [15:0] pitch_out;
        logic        was_filled;
        logic        last_of_run;
    } result_t;

    // Reset value of the max_gap_frames register.
    localparam logic [4:0] MAX_GAP_RESET = 5'd8;

    // Width of a Q5.16 log2 value of a 17-bit code.
    localparam int LOG_W = 21;

    // Fraction bits of the log2 domain and the value 1.0 in it.
    localparam int LOG_FRAC = 16;
    localparam logic [LOG_W-1:0] LOG_ONE = LOG_W'(1) << LOG_FRAC;

    // The mantissa of the squaring unit is kept in Q1.30.
    localparam int MANT_W = 31;

    // Largest pitch code.
    localparam logic [15:0] PITCH_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ----- src/pitch_contour_octave_fix_gap_fill.sv -----
// Top level of the pitch contour octave fix and gap fill block.
// Uses pcgf_pkg for the item types and fixed-point constants.
// Contains the sequencer, the shared log2 squaring unit and the divider.
`default_nettype none

// Channel   Direction  Handshake              Payload
// frame     in         frame_valid/stall      pcgf_pkg::frame_t
// result    out        result_valid/stall     pcgf_pkg::result_t
// cfg       in         cfg_valid/cfg_ready    max_gap_frames (5 bits)
//
// An item is taken while the sequencer is idle; an item that only gets held back gives no result.
// Zero results come from S_ZERO and wait while the output is stalled. A filled run
// of g frames costs two log2 runs, then per frame an accumulation, DW divider steps
// (DW = 23 plus the bits of the gap count, 28 by default) and up to 16 binary
// search steps on the shared log2 unit. The exp2 search is the largest part of that work.
// Reset clears all contour state and sets max_gap_frames to 8. A stalled result
// holds the sequencer; the next item is taken once the last result of the current
// one sits in the output register.

module pitch_contour_octave_fix_gap_fill #(
    parameter int MAX_GAP = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             frame_valid,
    output logic                  frame_stall,
    input  wire pcgf_pkg::frame_t frame,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output pcgf_pkg::result_t     result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [4:0]       cfg_data
);

    localparam int CNT_W = $clog2(MAX_GAP + 1);
    localparam int ZC_W  = $clog2(MAX_GAP + 2);
    localparam int DIFF_W = pcgf_pkg::LOG_W + 1;
    localparam int NUM_W = DIFF_W + CNT_W;
    localparam int DVD_W = NUM_W + 1;
    localparam int DV_W  = CNT_W + 2;
    localparam int REM_W = CNT_W + 3;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int L_W   = DVD_W + 2;
    localparam int MW    = pcgf_pkg::MANT_W;
    localparam int LW    = pcgf_pkg::LOG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ZERO, S_LOG0, S_LOG1, S_ACC, S_DIVSET, S_DIV, S_LSET,
        S_MID, S_EXPW, S_EMIT_FILL, S_EMIT_F
    } state_t;

    state_t state_reg, state_next;

    // Configuration and contour state.
    logic [4:0]       max_gap_frames_reg;
    logic [15:0]      prev_fixed_reg;
    logic [15:0]      last_voiced_reg;
    logic             seen_voiced_reg;
    logic [CNT_W-1:0] held_reg;
    logic             long_gap_reg;

    // Plan of the current item.
    logic [15:0]      f_reg;
    logic [ZC_W-1:0]  zero_cnt_reg;
    logic [CNT_W-1:0] fill_left_reg;
    logic [CNT_W-1:0] gap_reg;
    logic             emit_f_reg;

    // Interpolation datapath.
    logic [LW-1:0]           l0_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic [L_W-1:0]          lim_reg;
    logic [16:0]             lo_reg;
    logic [16:0]             hi_reg;
    logic [16:0]             mid_reg;

    // Output register.
    logic                result_valid_reg;
    pcgf_pkg::result_t   result_reg;

    // Shared log2 unit.
    logic                lg_start;
    logic [16:0]         lg_x;
    logic                lg_busy_reg;
    logic                lg_done_reg;
    logic [MW-1:0]       lg_m_reg;
    logic [LW-1:0]       lg_r_reg;
    logic [3:0]          lg_cnt_reg;

    assign frame_stall  = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    logic accept;
    logic out_free;
    assign accept   = frame_valid && (state_reg == S_IDLE);
    assign out_free = !result_valid_reg || !result_stall;

    // Octave fix and planning of an arriving item.
    logic [CNT_W-1:0] limit;
    logic [20:0]      c20, c9, c11;
    logic [16:0]      dbl;
    logic [15:0]      f_new;
    logic             voiced;
    logic             do_fill;
    logic [ZC_W-1:0]  zc;
    logic [CNT_W-1:0] held_new;
    logic             long_new;
    logic             over_limit;

    always_comb
    begin
        if (32'(max_gap_frames_reg) > 32'(MAX_GAP))
            limit = CNT_W'(MAX_GAP);
        else
            limit = CNT_W'(max_gap_frames_reg);
        voiced = (frame.pitch_in != 16'd0);
        c20 = 21'(frame.pitch_in) * 21'd20;
        c9  = 21'(prev_fixed_reg) * 21'd9;
        c11 = 21'(prev_fixed_reg) * 21'd11;
        dbl = {frame.pitch_in, 1'b0};
        f_new = frame.pitch_in;
        if (prev_fixed_reg != 16'd0 && c20 > c9 && c20 < c11)
            f_new = dbl[16] ? pcgf_pkg::PITCH_MAX : dbl[15:0];
        over_limit = ({1'b0, held_reg} + (CNT_W+1)'(1)) > {1'b0, limit};
        do_fill  = 1'b0;
        zc       = '0;
        held_new = held_reg;
        long_new = long_gap_reg;
        if (voiced) begin
            do_fill = (held_reg != '0) && (held_reg <= limit) && seen_voiced_reg;
            if (held_reg != '0 && !do_fill)
                zc = ZC_W'(held_reg);
            held_new = '0;
            long_new = 1'b0;
        end else if (!seen_voiced_reg || long_gap_reg) begin
            zc = ZC_W'(1);
        end else if (over_limit) begin
            zc = ZC_W'(held_reg) + ZC_W'(1);
            held_new = '0;
            long_new = 1'b1;
        end else begin
            held_new = held_reg + CNT_W'(1);
        end
        if (frame.end_of_contour)
            zc = zc + ZC_W'(held_new);
    end

    // Fill arithmetic between registers.
    logic signed [NUM_W-1:0] num_acc;
    logic [NUM_W-1:0]        mag;
    logic [DV_W-1:0]         dv;
    logic [REM_W-1:0]        trial;
    logic signed [L_W-1:0]   l_s;
    logic [17:0]             mid_sum;
    logic [16:0]             mid_c;

    always_comb
    begin
        num_acc = num_reg + NUM_W'(diff_reg);
        mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        dv = DV_W'({1'b0, gap_reg} + (CNT_W+1)'(1)) << 1;
        trial = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
        if (num_reg[NUM_W-1])
            l_s = L_W'(l0_reg) - L_W'(dvd_reg);
        else
            l_s = L_W'(l0_reg) + L_W'(dvd_reg);
        mid_sum = 18'(lo_reg) + 18'(hi_reg) + 18'd1;
        mid_c = mid_sum[17:1];
    end

    // Start requests for the shared log2 unit.
    always_comb
    begin
        lg_start = 1'b0;
        lg_x = 17'(f_reg);
        case (state_reg)
            S_IDLE:
            begin
                lg_start = accept && voiced && do_fill;
                lg_x = 17'(last_voiced_reg);
            end
            S_LOG0:
            begin
                lg_start = lg_done_reg;
                lg_x = 17'(f_reg);
            end
            S_MID:
            begin
                lg_start = (lo_reg < hi_reg);
                lg_x = {mid_c[15:0], 1'b0} - 17'd1;
            end
            default:
            begin
                lg_start = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (voiced && do_fill)
                        state_next = S_LOG0;
                    else if (zc != '0)
                        state_next = S_ZERO;
                    else if (voiced)
                        state_next = S_EMIT_F;
                end
            end
            S_ZERO:
            begin
                if (out_free && zero_cnt_reg == ZC_W'(1))
                    state_next = emit_f_reg ? S_EMIT_F : S_IDLE;
            end
            S_LOG0:      if (lg_done_reg) state_next = S_LOG1;
            S_LOG1:      if (lg_done_reg) state_next = S_ACC;
            S_ACC:       state_next = S_DIVSET;
            S_DIVSET:    state_next = S_DIV;
            S_DIV:       if (dcnt_reg == DCNT_W'(1)) state_next = S_LSET;
            S_LSET:      state_next = S_MID;
            S_MID:       state_next = (lo_reg < hi_reg) ? S_EXPW : S_EMIT_FILL;
            S_EXPW:      if (lg_done_reg) state_next = S_MID;
            S_EMIT_FILL:
            begin
                if (out_free)
                    state_next = (fill_left_reg == CNT_W'(1)) ? S_EMIT_F : S_ACC;
            end
            S_EMIT_F:    if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Sequencer, contour state, divider and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= S_IDLE;
            max_gap_frames_reg <= pcgf_pkg::MAX_GAP_RESET;
            prev_fixed_reg     <= '0;
            last_voiced_reg    <= '0;
            seen_voiced_reg    <= 1'b0;
            held_reg           <= '0;
            long_gap_reg       <= 1'b0;
            f_reg              <= '0;
            zero_cnt_reg       <= '0;
            fill_left_reg      <= '0;
            gap_reg            <= '0;
            emit_f_reg         <= 1'b0;
            l0_reg             <= '0;
            diff_reg           <= '0;
            num_reg            <= '0;
            dvd_reg            <= '0;
            rem_reg            <= '0;
            dcnt_reg           <= '0;
            lim_reg            <= '0;
            lo_reg             <= '0;
            hi_reg             <= '0;
            mid_reg            <= '0;
            result_valid_reg   <= 1'b0;
            result_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid)
                max_gap_frames_reg <= cfg_data;
            if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        f_reg         <= f_new;
                        zero_cnt_reg  <= zc;
                        emit_f_reg    <= voiced;
                        fill_left_reg <= held_reg;
                        gap_reg       <= held_reg;
                        if (voiced) begin
                            prev_fixed_reg  <= f_new;
                            last_voiced_reg <= f_new;
                            seen_voiced_reg <= 1'b1;
                        end else begin
                            prev_fixed_reg  <= '0;
                        end
                        held_reg     <= held_new;
                        long_gap_reg <= long_new;
                        if (frame.end_of_contour) begin
                            prev_fixed_reg  <= '0;
                            last_voiced_reg <= '0;
                            seen_voiced_reg <= 1'b0;
                            held_reg        <= '0;
                            long_gap_reg    <= 1'b0;
                        end
                    end
                end
                S_ZERO:
                begin
                    if (out_free) begin
                        result_valid_reg       <= 1'b1;
                        result_reg.pitch_out   <= '0;
                        result_reg.was_filled  <= 1'b0;
                        result_reg.last_of_run <= (zero_cnt_reg == ZC_W'(1)) && !emit_f_reg;
                        zero_cnt_reg           <= zero_cnt_reg - ZC_W'(1);
                    end
                end
                S_LOG0:
                begin
                    if (lg_done_reg)
                        l0_reg <= lg_r_reg;
                end
                S_LOG1:
                begin
                    if (lg_done_reg) begin
                        diff_reg <= DIFF_W'(lg_r_reg) - DIFF_W'(l0_reg);
                        num_reg  <= '0;
                    end
                end
                S_ACC:
                begin
                    num_reg <= num_acc;
                end
                S_DIVSET:
                begin
                    // Rounded quotient: (2*|num| + den) / (2*den).
                    dvd_reg  <= {mag, 1'b0} + DVD_W'(gap_reg) + DVD_W'(1);
                    rem_reg  <= '0;
                    dcnt_reg <= DCNT_W'(DVD_W);
                end
                S_DIV:
                begin
                    if (trial >= REM_W'(dv)) begin
                        rem_reg <= trial - REM_W'(dv);
                        dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                end
                S_LSET:
                begin
                    if (l_s[L_W-1])
                        lim_reg <= L_W'(pcgf_pkg::LOG_ONE);
                    else
                        lim_reg <= L_W'(l_s) + L_W'(pcgf_pkg::LOG_ONE);
                    lo_reg <= 17'd1;
                    hi_reg <= 17'(pcgf_pkg::PITCH_MAX);
                end
                S_MID:
                begin
                    mid_reg <= mid_c;
                end
                S_EXPW:
                begin
                    if (lg_done_reg) begin
                        if (L_W'(lg_r_reg) <= lim_reg)
                            lo_reg <= mid_reg;
                        else
                            hi_reg <= mid_reg - 17'd1;
                    end
                end
                S_EMIT_FILL:
                begin
                    if (out_free) begin
                        result_valid_reg       <= 1'b1;
                        result_reg.pitch_out   <= lo_reg[15:0];
                        result_reg.was_filled  <= 1'b1;
                        result_reg.last_of_run <= 1'b0;
                        fill_left_reg          <= fill_left_reg - CNT_W'(1);
                    end
                end
                S_EMIT_F:
                begin
                    if (out_free) begin
                        result_valid_reg       <= 1'b1;
                        result_reg.pitch_out   <= f_reg;
                        result_reg.was_filled  <= 1'b0;
                        result_reg.last_of_run <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Shared log2 unit: normalize, then one squaring of the Q1.30 mantissa per
    // cycle for each of the 16 fraction bits, truncating.
    logic [4:0]        lg_n;
    logic [MW-1:0]     lg_m0;
    logic [2*MW-1:0]   lg_sq;
    logic [MW:0]       lg_t;

    always_comb
    begin
        lg_n = '0;
        for (int k = 1; k < 17; k++) begin
            if (lg_x[k])
                lg_n = 5'(k);
        end
        lg_m0 = MW'({14'd0, lg_x}) << (5'd30 - lg_n);
        lg_sq = (2*MW)'(lg_m_reg) * (2*MW)'(lg_m_reg);
        lg_t  = lg_sq[2*MW-1:MW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lg_busy_reg <= 1'b0;
            lg_done_reg <= 1'b0;
            lg_m_reg    <= '0;
            lg_r_reg    <= '0;
            lg_cnt_reg  <= '0;
        end else begin
            lg_done_reg <= 1'b0;
            if (lg_start) begin
                lg_busy_reg <= 1'b1;
                lg_m_reg    <= lg_m0;
                lg_r_reg    <= LW'(lg_n) << pcgf_pkg::LOG_FRAC;
                lg_cnt_reg  <= 4'd15;
            end else if (lg_busy_reg) begin
                if (lg_t[MW]) begin
                    lg_m_reg <= lg_t[MW:1];
                    lg_r_reg <= lg_r_reg | (LW'(1) << lg_cnt_reg);
                end else begin
                    lg_m_reg <= lg_t[MW-1:0];
                end
                lg_cnt_reg <= lg_cnt_reg - 4'd1;
                if (lg_cnt_reg == 4'd0) begin
                    lg_busy_reg <= 1'b0;
                    lg_done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
